// ----- hdl/tss_pkg.sv -----
package tss_pkg;

  localparam int MAX_TASKS_DEF = 32;
  localparam int TIME_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int IDX_OUT_W     = 5;
  localparam int DELAY_W       = 21;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } tss_state_t;

  typedef struct packed {
    logic load;       // take one task beat into the store
    logic scan_init;  // restart the selection scan
    logic scan_step;  // issue one store read
    logic emit_done;  // current pick was delivered
    logic clear;      // set finished, back to empty
  } tss_cmd_t;

  typedef struct packed {
    logic scan_last;  // read issued now is the last entry
    logic emit_last;  // pick on offer is the final one
  } tss_sts_t;

endpackage

// ----- hdl/task_slack_sorter.sv -----
// task slack sorter
// input channel (in_valid/in_ready): one beat per task carrying exec_time,
// deadline and last_task. beats are taken one per cycle while loading.
// tasks past MAX_TASKS are dropped and flag overflowed for the whole set.
// the beat with last_task high ends the set and starts ordering; in_ready
// stays low until every result of the set has been delivered.
// output channel (out_valid/out_ready): one beat per kept task, arrival index
// in order of largest slack (deadline - exec_time) first, ties lowest index
// first, with total_delay and overflowed repeated and last_result on the
// final beat.
// each result takes a full scan of the slack store through its single
// registered read port and a drain state for the last compare, and out_valid
// rises in the emit state that follows; the next scan starts only once the
// current result has been taken.
// a stalled receiver simply holds the current result; nothing advances.
// synchronous reset empties the store and returns to loading.
module task_slack_sorter
  import tss_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   exec_time,
  input  logic [FIELD_W-1:0]   deadline,
  input  logic                 last_task,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_OUT_W-1:0] task_index,
  output logic [DELAY_W-1:0]   total_delay,
  output logic                 overflowed,
  output logic                 last_result
);

  tss_cmd_t cmd;
  tss_sts_t sts;

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_task (last_task),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  tss_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .exec_time   (exec_time),
    .deadline    (deadline),
    .task_index  (task_index),
    .total_delay (total_delay),
    .overflowed  (overflowed),
    .last_result (last_result)
  );

endmodule

// ----- hdl/tss_ctrl.sv -----
module tss_ctrl
  import tss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_task,
  input  logic     out_ready,
  input  tss_sts_t sts,
  output tss_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  tss_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_task) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is compared in this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_done = 1'b1;
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- hdl/tss_dpath.sv -----
module tss_dpath
  import tss_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tss_cmd_t             cmd,
  output tss_sts_t             sts,
  input  logic [FIELD_W-1:0]   exec_time,
  input  logic [FIELD_W-1:0]   deadline,
  output logic [IDX_OUT_W-1:0] task_index,
  output logic [DELAY_W-1:0]   total_delay,
  output logic                 overflowed,
  output logic                 last_result
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int SLK_W = TIME_BITS + 1;
  localparam int SUM_W = TIME_BITS + CNT_W;
  localparam int EXT_W = (SUM_W > DELAY_W) ? SUM_W : DELAY_W;

  logic signed [SLK_W-1:0] slack_mem [MAX_TASKS];
  logic signed [SLK_W-1:0] rd_slack;
  logic [MAX_TASKS-1:0]    taken;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        emit_cnt;
  logic [SUM_W-1:0]        exec_sum;
  logic [SUM_W-1:0]        dl_sum;
  logic                    overflow;
  logic [IDX_W-1:0]        scan_addr;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_vld;
  logic [IDX_W-1:0]        best_idx;
  logic signed [SLK_W-1:0] best_slack;
  logic                    found;

  logic [TIME_BITS+FIELD_W-1:0] e_ext, d_ext;
  logic [TIME_BITS-1:0]         e_val, d_val;
  logic signed [SLK_W-1:0]      new_slack;
  logic                         room;
  logic                         cand;
  logic [EXT_W-1:0]             diff;
  logic [IDX_W+IDX_OUT_W-1:0]   idx_ext;

  // mask input fields to the configured time width
  assign e_ext     = (TIME_BITS+FIELD_W)'(exec_time);
  assign d_ext     = (TIME_BITS+FIELD_W)'(deadline);
  assign e_val     = e_ext[TIME_BITS-1:0];
  assign d_val     = d_ext[TIME_BITS-1:0];
  assign new_slack = $signed({1'b0, d_val}) - $signed({1'b0, e_val});
  assign room      = (count != CNT_W'(MAX_TASKS));

  // slack store, one write port for loading and one registered read for the scan
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      slack_mem[count[IDX_W-1:0]] <= new_slack;
    end
    rd_slack <= slack_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      exec_sum <= '0;
      dl_sum   <= '0;
      overflow <= 1'b0;
      taken    <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.load) begin
        if (room) begin
          count    <= count + 1'b1;
          exec_sum <= exec_sum + SUM_W'(e_val);
          dl_sum   <= dl_sum + SUM_W'(d_val);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.emit_done) begin
        taken[best_idx] <= 1'b1;
        emit_cnt        <= emit_cnt + 1'b1;
      end
    end
  end

  // scan: address counter, one read per cycle, compare in the cycle after the read
  assign cand = rd_vld && !taken[rd_idx] && (!found || rd_slack > best_slack);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step;
      if (cmd.scan_init) begin
        found <= 1'b0;
      end else if (cand) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (cmd.scan_init) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (cand) begin
      best_idx   <= rd_idx;
      best_slack <= rd_slack;
    end
  end

  assign sts.scan_last = (CNT_W'(scan_addr) == count - 1'b1);
  assign sts.emit_last = (emit_cnt == count - 1'b1);

  // saturating delay from the two running sums
  assign diff        = (exec_sum > dl_sum) ? EXT_W'(exec_sum - dl_sum) : '0;
  assign total_delay = (diff > EXT_W'(DELAY_MAX)) ? DELAY_MAX : diff[DELAY_W-1:0];
  assign idx_ext     = (IDX_W+IDX_OUT_W)'(best_idx);
  assign task_index  = idx_ext[IDX_OUT_W-1:0];
  assign overflowed  = overflow;
  assign last_result = sts.emit_last;

  a_pick_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_done |-> found && !taken[best_idx])
    else $error("delivered pick not found or already taken");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_done |-> emit_cnt < count)
    else $error("more picks than stored tasks");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("task count beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> count == '0 && !overflow && taken == '0)
    else $error("set state not cleared");

endmodule
